// ===== design/tsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfe_pkg
// Shared types, command bytes and segment table for the temperature segment
// frame encoder.
// ----------------------------------------------------------------------------
package tsfe_pkg;

  localparam int unsigned FrameLen = 7;
  localparam int unsigned CntW     = $clog2(FrameLen);

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h8F;
  localparam logic [7:0] DP_BIT    = 8'h01;
  localparam logic [7:0] TEST_EVEN = 8'hFF;
  localparam logic [7:0] TEST_ODD  = 8'hFE;
  localparam logic [9:0] MAG_LIMIT = 10'd999;

  localparam logic [FrameLen-1:0] START_MASK = 7'b1000011;
  localparam logic [FrameLen-1:0] STOP_MASK  = 7'b1100001;

  localparam logic [CntW-1:0] POS_CMD_DATA = 3'd0;
  localparam logic [CntW-1:0] POS_CMD_ADDR = 3'd1;
  localparam logic [CntW-1:0] POS_D0       = 3'd2;
  localparam logic [CntW-1:0] POS_D1       = 3'd3;
  localparam logic [CntW-1:0] POS_D2       = 3'd4;
  localparam logic [CntW-1:0] POS_D3       = 3'd5;
  localparam logic [CntW-1:0] POS_CMD_CTRL = 3'd6;

  typedef struct packed {
    logic       test;
    logic       neg;
    logic [3:0] hund;
    logic [6:0] rem;
  } split_t;

  typedef struct packed {
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
  } frame_data_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hFC;
      4'd1:    code = 8'h60;
      4'd2:    code = 8'hDA;
      4'd3:    code = 8'hF2;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'hB6;
      4'd6:    code = 8'hBE;
      4'd7:    code = 8'hE0;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'hF6;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== design/tsfe_split.sv =====
// ----------------------------------------------------------------------------
// tsfe_split
// Three pipeline stages: saturate the magnitude, extract the hundreds digit,
// form the remainder below one hundred.
// ----------------------------------------------------------------------------
module tsfe_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_test,
  input  logic signed [15:0]    in_temp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tsfe_pkg::split_t      out_word
);
  import tsfe_pkg::*;

  logic        v1_r, v2_r, v3_r;
  logic        s1, s2, s3;
  logic        test1_r, neg1_r, test2_r, neg2_r;
  logic [9:0]  mag1_r, mag2_r;
  logic [3:0]  hund2_r;
  split_t      word3_r;
  logic [15:0] abs_val;
  logic [9:0]  mag_sat;
  logic [15:0] hund_prod;
  logic [9:0]  hund_x100;
  logic [9:0]  rem_full;

  assign s3       = v3_r && out_stall;
  assign s2       = v2_r && s3;
  assign s1       = v1_r && s2;
  assign in_stall = s1;

  assign abs_val   = in_temp[15] ? (16'd0 - 16'(in_temp)) : 16'(in_temp);
  assign mag_sat   = (abs_val > 16'(MAG_LIMIT)) ? MAG_LIMIT : abs_val[9:0];
  assign hund_prod = 16'(mag1_r) * 16'd41;
  assign hund_x100 = 10'(hund2_r) * 10'd100;
  assign rem_full  = mag2_r - hund_x100;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!s1) v1_r <= in_valid;
      if (!s2) v2_r <= v1_r;
      if (!s3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1) begin
      test1_r <= in_test;
      neg1_r  <= in_temp[15];
      mag1_r  <= mag_sat;
    end
    if (!s2) begin
      test2_r <= test1_r;
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      hund2_r <= hund_prod[15:12];
    end
    if (!s3) begin
      word3_r.test <= test2_r;
      word3_r.neg  <= neg2_r;
      word3_r.hund <= hund2_r;
      word3_r.rem  <= rem_full[6:0];
    end
  end

  assign out_valid = v3_r;
  assign out_word  = word3_r;

endmodule

// ===== design/tsfe_encode.sv =====
// ----------------------------------------------------------------------------
// tsfe_encode
// Two pipeline stages: split the remainder into tens and units, then map the
// digits to segment codes and build the four display data bytes.
// ----------------------------------------------------------------------------
module tsfe_encode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tsfe_pkg::split_t      in_word,
  input  logic [7:0]            icon_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tsfe_pkg::frame_data_t out_data
);
  import tsfe_pkg::*;

  logic        v4_r, v5_r;
  logic        s4, s5;
  split_t      word4_r;
  logic [3:0]  tens4_r;
  frame_data_t data5_r;
  logic [14:0] tens_prod;
  logic [6:0]  tens_x10;
  logic [6:0]  units_full;
  frame_data_t data_nxt;

  assign s5       = v5_r && out_stall;
  assign s4       = v4_r && s5;
  assign in_stall = s4;

  assign tens_prod  = 15'(in_word.rem) * 15'd205;
  assign tens_x10   = 7'(tens4_r) * 7'd10;
  assign units_full = word4_r.rem - tens_x10;

  always_comb begin
    if (word4_r.test) begin
      data_nxt.d0 = TEST_EVEN;
      data_nxt.d1 = TEST_ODD;
      data_nxt.d2 = TEST_EVEN;
      data_nxt.d3 = TEST_ODD;
    end else begin
      data_nxt.d0 = icon_bits;
      data_nxt.d1 = (word4_r.hund == 4'd0) ? 8'h00 : seg_code(word4_r.hund);
      data_nxt.d2 = seg_code(tens4_r) | DP_BIT;
      data_nxt.d3 = seg_code(units_full[3:0]) | (word4_r.neg ? DP_BIT : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (!s4) v4_r <= in_valid;
      if (!s5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s4) begin
      word4_r <= in_word;
      tens4_r <= tens_prod[14:11];
    end
    if (!s5) begin
      data5_r <= data_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = data5_r;

endmodule

// ===== design/tsfe_ser.sv =====
// ----------------------------------------------------------------------------
// tsfe_ser
// Frame serializer: holds one request's data bytes and sends the seven words
// of the frame with their start, stop and last flags.
// ----------------------------------------------------------------------------
module tsfe_ser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tsfe_pkg::frame_data_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_start,
  output logic                  out_stop,
  output logic                  out_last
);
  import tsfe_pkg::*;

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  frame_data_t     data_r;
  logic            out_fire;
  logic            at_end;
  logic            load;

  assign out_fire = busy_r && !out_stall;
  assign at_end   = (cnt_r == POS_CMD_CTRL);
  assign load     = !busy_r || (out_fire && at_end);
  assign in_stall = !load;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = in_valid;
      cnt_nxt  = POS_CMD_DATA;
    end else if (out_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= POS_CMD_DATA;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) data_r <= in_data;
  end

  always_comb begin
    unique case (cnt_r)
      POS_CMD_DATA: out_byte = CMD_DATA;
      POS_CMD_ADDR: out_byte = CMD_ADDR;
      POS_D0:       out_byte = data_r.d0;
      POS_D1:       out_byte = data_r.d1;
      POS_D2:       out_byte = data_r.d2;
      POS_D3:       out_byte = data_r.d3;
      POS_CMD_CTRL: out_byte = CMD_CTRL;
      default:      out_byte = CMD_CTRL;
    endcase
  end

  assign out_valid = busy_r;
  assign out_start = START_MASK[cnt_r];
  assign out_stop  = STOP_MASK[cnt_r];
  assign out_last  = at_end;

endmodule

// ===== design/temperature_segment_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// temperature_segment_frame_encoder
// A request passes the split and encode stages, then the serializer loads it.
// One word per cycle unless out_stall; a new request loads as the last word leaves.
// Five pipeline stages ahead of the serializer absorb requests while a frame drains.
// Reset (synchronous, active low) empties the pipeline and clears icon_bits.
// ----------------------------------------------------------------------------
module temperature_segment_frame_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [15:0] in_temp_tenths,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_start_before,
  output logic               out_stop_after,
  output logic               out_last
);
  import tsfe_pkg::*;

  logic [7:0]  icon_r;
  logic        split_valid, split_stall;
  split_t      split_word;
  logic        enc_valid, enc_stall;
  frame_data_t enc_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icon_r <= 8'h00;
    end else if (cfg_wr_en) begin
      icon_r <= cfg_wr_data;
    end
  end

  tsfe_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_test   (in_req_type),
    .in_temp   (in_temp_tenths),
    .out_valid (split_valid),
    .out_stall (split_stall),
    .out_word  (split_word)
  );

  tsfe_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_stall  (split_stall),
    .in_word   (split_word),
    .icon_bits (icon_r),
    .out_valid (enc_valid),
    .out_stall (enc_stall),
    .out_data  (enc_data)
  );

  tsfe_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (enc_valid),
    .in_stall  (enc_stall),
    .in_data   (enc_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_frame_byte),
    .out_start (out_start_before),
    .out_stop  (out_stop_after),
    .out_last  (out_last)
  );

endmodule

// ===== design/tsfe_checker.sv =====
// ----------------------------------------------------------------------------
// tsfe_checker
// Port-level checks of frame structure and output handshake, bound to the
// top level.
// ----------------------------------------------------------------------------
module tsfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_start_before,
  input logic       out_stop_after,
  input logic       out_last
);
  import tsfe_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte))
    else $error("stalled word changed");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a frame");

  a_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_start_before && out_stop_after
                              && (out_frame_byte == CMD_CTRL))
    else $error("last word is not the control command");

  a_addr_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_before && !out_stop_after |-> out_frame_byte == CMD_ADDR)
    else $error("address command byte wrong");

endmodule

bind temperature_segment_frame_encoder tsfe_checker u_tsfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_byte   (out_frame_byte),
  .out_start_before (out_start_before),
  .out_stop_after   (out_stop_after),
  .out_last         (out_last)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame encoder bench
// Sends show-temperature and test-pattern requests to the encoder, rebuilds
// the seven-word display frame for each accepted request, and compares every
// word leaving the block in order. The sender runs in bursts and the receiver
// stalls on its own pattern. The icon byte is rewritten between idle phases.
// ----------------------------------------------------------------------------
module tb;

  typedef enum logic {REQ_SHOW = 1'b0, REQ_TEST = 1'b1} req_e;

  localparam logic [7:0] DATA_CMD = 8'h40;
  localparam logic [7:0] ADDR_CMD = 8'hC0;
  localparam logic [7:0] CTRL_CMD = 8'h8F;
  localparam logic [7:0] DOT      = 8'h01;
  localparam logic [7:0] TEST_HI  = 8'hFF;
  localparam logic [7:0] TEST_LO  = 8'hFE;
  localparam int         MAX_MAG  = 999;
  localparam int         WORDS    = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       last;
  } word_t;

  class frame_tracker;
    logic [7:0] icon;
    word_t      due_words[$];
    int         errors;
    logic [7:0] digit_seg[10];

    function new();
      icon      = 8'h00;
      errors    = 0;
      digit_seg = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
                    8'hFE, 8'hF6};
    endfunction

    function void set_icon(logic [7:0] value);
      icon = value;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void encode_request(req_e req, logic signed [15:0] temp);
      logic [7:0] bytes[WORDS];
      logic       neg;
      logic       start_bit;
      logic       stop_bit;
      logic       last_bit;
      int         mag;
      int         hund;
      int         tens;
      int         ones;
      neg = temp[15];
      mag = neg ? -int'(temp) : int'(temp);
      if (mag > MAX_MAG) mag = MAX_MAG;
      hund = mag / 100;
      tens = (mag / 10) % 10;
      ones = mag % 10;
      bytes[0] = DATA_CMD;
      bytes[1] = ADDR_CMD;
      bytes[6] = CTRL_CMD;
      if (req == REQ_TEST) begin
        bytes[2] = TEST_HI;
        bytes[3] = TEST_LO;
        bytes[4] = TEST_HI;
        bytes[5] = TEST_LO;
      end else begin
        bytes[2] = icon;
        bytes[3] = (hund == 0) ? 8'h00 : digit_seg[hund];
        bytes[4] = digit_seg[tens] | DOT;
        bytes[5] = digit_seg[ones] | (neg ? DOT : 8'h00);
      end
      for (int k = 0; k < WORDS; k++) begin
        start_bit = (k < 2) || (k == WORDS - 1);
        stop_bit  = (k == 0) || (k == 5) || (k == WORDS - 1);
        last_bit  = (k == WORDS - 1);
        due_words.push_back({bytes[k], start_bit, stop_bit, last_bit});
      end
    endfunction

    function void match_word(word_t got);
      word_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, %s %02h start %0b stop %0b last %0b",
                 $time, "actual byte", got.data, got.start, got.stop, got.last);
        return;
      end
      want = due_words.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected byte %02h start %0b stop %0b last %0b, %s",
                 $time, want.data, want.start, want.stop, want.last, "actual");
        $display("%0t:   actual byte %02h start %0b stop %0b last %0b",
                 $time, got.data, got.start, got.stop, got.last);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [7:0]         cfg_wr_data    = 8'h00;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_req_type    = 1'b0;
  logic signed [15:0] in_temp_tenths = 16'sd0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_start_before;
  logic               out_stop_after;
  logic               out_last;

  frame_tracker frames = new();
  int burst_left = 4;
  int stall_mode = 0;
  int cyc        = 0;

  temperature_segment_frame_encoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_temp_tenths   (in_temp_tenths),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      frames.match_word({out_frame_byte, out_start_before, out_stop_after, out_last});
    if (cyc % 40 == 0) stall_mode = $urandom_range(0, 3);
    cyc++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cyc % 6) < 2);
    endcase
  end

  task automatic send_request(input req_e req, input logic signed [15:0] temp);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_temp_tenths <= temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames.encode_request(req, temp);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_icon(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frames.set_icon(value);
  endtask

  function automatic logic signed [15:0] pick_temp();
    logic signed [15:0] edges[8];
    int v;
    edges = '{16'sd999, -16'sd999, 16'sd1000, -16'sd1000, 16'sd0, -16'sd32768,
              16'sd32767, -16'sd1};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = int'($urandom_range(0, 2000)) - 1000;
        return v[15:0];
      end
      6, 7:    return 16'($urandom);
      8:       return edges[$urandom_range(0, 7)];
      default: return 16'($urandom_range(0, 99));
    endcase
  endfunction

  logic signed [15:0] directed_temps[20] = '{
    16'sd0, 16'sd5, 16'sd9, 16'sd10, 16'sd99, 16'sd100, 16'sd101, 16'sd999,
    16'sd1000, 16'sd32767, -16'sd1, -16'sd9, -16'sd10, -16'sd999, -16'sd1000,
    -16'sd32768, 16'sd123, -16'sd456, 16'sd789, -16'sd120
  };

  logic [7:0] icon_values[4];

  initial begin
    icon_values = '{8'hFF, 8'h00, 8'h00, 8'h00};
    icon_values[2] = 8'($urandom);
    icon_values[3] = 8'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_temps[i]) send_request(REQ_SHOW, directed_temps[i]);
    send_request(REQ_TEST, 16'sd0);
    send_request(REQ_TEST, -16'sd32768);
    send_request(REQ_TEST, 16'sd32767);
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_icon(icon_values[phase]);
      repeat (50)
        send_request(($urandom_range(0, 3) == 0) ? REQ_TEST : REQ_SHOW, pick_temp());
    end
    wait_idle();
    if (frames.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
